/* rtl/lpam_pkg.sv */
// ----------------------------------------------------------------------------
// lpam_pkg
// Shared types and constants for the largest-prime-at-most core.
// ----------------------------------------------------------------------------
package lpam_pkg;

    localparam logic [63:0] CACHE_BASE    = 64'((1 << 24) / 64);
    localparam int          CACHE_SHIFT   = $clog2((1 << 17) / 64);
    localparam logic [63:0] DATASET_BASE  = 64'((1 << 30) / 128);
    localparam int          DATASET_SHIFT = $clog2((1 << 23) / 128);

    typedef enum logic [1:0] {
        REQ_DIRECT  = 2'd0,
        REQ_CACHE   = 2'd1,
        REQ_DATASET = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_mod_ctl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_sts;

endpackage

/* rtl/lpam_mod.sv */
// ----------------------------------------------------------------------------
// lpam_mod
// Bit-serial remainder unit: one dividend bit per cycle, flags a zero
// remainder when the last bit has been shifted in.
// ----------------------------------------------------------------------------
module lpam_mod
    import lpam_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIV_WIDTH   = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mod_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]   i_divisor,
    output t_mod_sts               o_sts
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_run,   n_run;
    logic                   r_done,  n_done;
    logic [CW-1:0]          r_cnt,   n_cnt;
    logic [DIV_WIDTH-1:0]   r_rem,   n_rem;
    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [DIV_WIDTH:0]     w_rem_sh;

    assign w_rem_sh = {r_rem, r_shift[VALUE_WIDTH-1]};

    always_comb begin
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_shift = r_shift;
        if (i_ctl.start) begin
            n_run   = 1'b1;
            n_cnt   = CW'(VALUE_WIDTH);
            n_rem   = '0;
            n_shift = i_dividend;
        end else if (r_run) begin
            if (w_rem_sh >= {1'b0, i_divisor}) begin
                n_rem = DIV_WIDTH'(w_rem_sh - {1'b0, i_divisor});
            end else begin
                n_rem = DIV_WIDTH'(w_rem_sh);
            end
            n_shift = r_shift << 1;
            n_cnt   = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_shift <= n_shift;
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = (r_rem == '0);

endmodule

/* rtl/largest_prime_at_most_core.sv */
// ----------------------------------------------------------------------------
// largest_prime_at_most_core
// Largest prime not above a bound, by trial division with odd divisors.
// ----------------------------------------------------------------------------
// Bounds of 2 or less skip trial division; otherwise each divisor tried, over
//   all candidates, runs the serial remainder unit once.
// The serial remainder unit takes one dividend bit per cycle.
// Throughput: one request at a time; busy stays high through o_done.
// Results cannot be stalled.
// Reset: synchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module largest_prime_at_most_core
    import lpam_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_request_value,
    output logic        o_done,
    output logic [31:0] o_prime_result
);

    localparam int W   = VALUE_WIDTH;
    localparam int DW  = (W + 1) / 2 + 1;
    localparam int DQW = 2 * DW;

    t_state          r_state,  n_state;
    logic            r_bad,    n_bad;
    logic [W-1:0]    r_cand,   n_cand;
    logic [W-1:0]    r_result, n_result;
    logic [DW-1:0]   r_div,    n_div;
    logic [DQW-1:0]  r_dsq,    n_dsq;
    logic [W-1:0]    w_bound;
    logic            w_bad;
    t_mod_ctl        w_ctl;
    t_mod_sts        w_sts;

    always_comb begin
        w_bad   = 1'b0;
        w_bound = W'(i_request_value);
        case (i_req_type)
            REQ_DIRECT:  w_bound = W'(i_request_value);
            REQ_CACHE:   w_bound = W'(CACHE_BASE + (64'(i_request_value) << CACHE_SHIFT));
            REQ_DATASET: w_bound = W'(DATASET_BASE + (64'(i_request_value) << DATASET_SHIFT));
            default:     w_bad   = 1'b1;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_bad       = r_bad;
        n_cand      = r_cand;
        n_result    = r_result;
        n_div       = r_div;
        n_dsq       = r_dsq;
        w_ctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_bad   = w_bad;
                    n_cand  = w_bound;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_bad || r_cand < W'(2)) begin
                    n_result = '0;
                    n_state  = S_DONE;
                end else if (r_cand == W'(2)) begin
                    n_result = W'(2);
                    n_state  = S_DONE;
                end else begin
                    n_cand  = r_cand[0] ? r_cand : r_cand - W'(1);
                    n_div   = DW'(3);
                    n_dsq   = DQW'(9);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_dsq > DQW'(r_cand)) begin
                    n_result = r_cand;
                    n_state  = S_DONE;
                end else begin
                    w_ctl.start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (w_sts.done) begin
                    if (w_sts.zero) begin
                        n_cand = r_cand - W'(2);
                        n_div  = DW'(3);
                        n_dsq  = DQW'(9);
                    end else begin
                        n_div = r_div + DW'(2);
                        n_dsq = r_dsq + (DQW'(r_div) << 2) + DQW'(4);
                    end
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad    <= n_bad;
        r_cand   <= n_cand;
        r_result <= n_result;
        r_div    <= n_div;
        r_dsq    <= n_dsq;
    end

    lpam_mod #(
        .VALUE_WIDTH (W),
        .DIV_WIDTH   (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_sts      (w_sts)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_prime_result = 32'(r_result);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but core not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("core still busy after result");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> r_state == S_MOD)
        else $error("remainder done outside of wait state");

    a_cand_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_MOD) |-> r_cand[0] && r_cand >= W'(3))
        else $error("candidate not odd or below three");
`endif

endmodule

/* verif/prime_result_checker.sv */
// ----------------------------------------------------------------------------
// prime_result_checker
// Watches the request and result channels of the largest-prime-at-most core.
// Each accepted request is turned into the expected prime by trial division,
// and every result strobe is compared against the oldest expected prime.
// ----------------------------------------------------------------------------
module prime_result_checker
    import lpam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_request_value,
    input  logic        i_done,
    input  logic [31:0] i_prime_result,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] CACHE_BOUND_BASE   = 64'd262144;
    localparam int          CACHE_EPOCH_SHIFT  = 11;
    localparam logic [63:0] DATASET_BOUND_BASE = 64'd8388608;
    localparam int          DATASET_EPOCH_SHIFT = 16;
    localparam logic [63:0] WORD_MASK          = 64'hFFFF_FFFF;

    logic [31:0] expected_primes [$];
    int          mismatches = 0;

    function automatic logic [31:0] largest_prime_le(input logic [1:0] rt,
                                                     input logic [31:0] val);
        logic [63:0] bound;
        logic [63:0] cand;
        logic [63:0] divisor;
        bit          found;
        case (rt)
            REQ_DIRECT:  bound = {32'd0, val};
            REQ_CACHE:   bound = (CACHE_BOUND_BASE
                                  + ({32'd0, val} << CACHE_EPOCH_SHIFT)) & WORD_MASK;
            REQ_DATASET: bound = (DATASET_BOUND_BASE
                                  + ({32'd0, val} << DATASET_EPOCH_SHIFT)) & WORD_MASK;
            default:     return 32'd0;
        endcase
        if (bound < 64'd2) return 32'd0;
        if (bound == 64'd2) return 32'd2;
        cand  = bound[0] ? bound : bound - 64'd1;
        found = 1'b0;
        while (!found) begin
            found   = 1'b1;
            divisor = 64'd3;
            while (found && divisor * divisor <= cand) begin
                if (cand % divisor == 64'd0) found = 1'b0;
                divisor += 64'd2;
            end
            if (!found) cand -= 64'd2;
        end
        return cand[31:0];
    endfunction

    assign o_fail_count = mismatches;

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n) begin
            if (i_done) begin
                if (expected_primes.size() == 0) begin
                    $error("prime_result: expected none pending, actual %0d",
                           i_prime_result);
                    mismatches++;
                end else begin
                    want = expected_primes.pop_front();
                    if (want !== i_prime_result) begin
                        $error("prime_result: expected %0d, actual %0d",
                               want, i_prime_result);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_primes.push_back(largest_prime_le(i_req_type, i_request_value));
            o_pending <= expected_primes.size();
        end
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the largest-prime-at-most core with a directed set of bounds and
// epochs, then random requests kept mostly to small bounds, with random idle
// gaps and a drain pause. Checking is done by prime_result_checker.
// ----------------------------------------------------------------------------
module testbench
    import lpam_pkg::*;
();

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 76;
    localparam int unsigned CYCLE_LIMIT  = 20_000_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  req_type      = 2'd0;
    logic [31:0] request_value = 32'd0;
    logic        done;
    logic [31:0] prime_result;
    int          fail_count;
    int          pending;
    int unsigned cycle_count   = 0;

    largest_prime_at_most_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (req_type),
        .i_request_value (request_value),
        .o_done          (done),
        .o_prime_result  (prime_result)
    );

    prime_result_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (req_type),
        .i_request_value (request_value),
        .i_done          (done),
        .i_prime_result  (prime_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("largest_prime_at_most_core: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [1:0] rt, input logic [31:0] v,
                                input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 19) begin
            if ($urandom_range(0, 1)) wait_drained();
            else start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start         <= 1'b1;
        req_type      <= rt;
        request_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pick_random(output logic [1:0] rt, output logic [31:0] v);
        int sel;
        sel = $urandom_range(0, 99);
        v   = $urandom();
        if (sel < 5) begin
            rt = REQ_UNUSED;
        end else if (sel < 60) begin
            rt = REQ_DIRECT;
            if (sel < 50) v = $urandom_range(0, 65535);
            else v = $urandom_range(0, 1 << 20);
        end else if (sel < 85) begin
            rt = REQ_CACHE;
            if ($urandom_range(0, 1)) v[20:0] = 21'($urandom_range(0, 63));
            else v[20:0] = 21'h1F_FF80 + 21'($urandom_range(0, 127));
        end else begin
            rt = REQ_DATASET;
            if ($urandom_range(0, 3) == 0) v[15:0] = 16'($urandom_range(0, 3));
            else v[15:0] = 16'hFF80 + 16'($urandom_range(0, 15));
        end
    endtask

    initial begin
        logic [1:0]  rt;
        logic [31:0] v;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_DIRECT,  32'd0,          1'b1);
        send_request(REQ_DIRECT,  32'd1,          1'b1);
        send_request(REQ_DIRECT,  32'd2,          1'b1);
        send_request(REQ_DIRECT,  32'd3,          1'b1);
        send_request(REQ_DIRECT,  32'd4,          1'b1);
        send_request(REQ_DIRECT,  32'd5,          1'b1);
        send_request(REQ_DIRECT,  32'd9,          1'b1);
        send_request(REQ_DIRECT,  32'd25,         1'b1);
        send_request(REQ_DIRECT,  32'd49,         1'b1);
        send_request(REQ_DIRECT,  32'd97,         1'b1);
        send_request(REQ_DIRECT,  32'd100,        1'b1);
        send_request(REQ_DIRECT,  32'd65536,      1'b1);
        send_request(REQ_DIRECT,  32'h00FF_FFFF,  1'b1);
        send_request(REQ_CACHE,   32'd0,          1'b1);
        send_request(REQ_CACHE,   32'd1,          1'b1);
        send_request(REQ_CACHE,   32'h001F_FF80,  1'b1);
        send_request(REQ_CACHE,   32'hFFFF_FF80,  1'b1);
        send_request(REQ_CACHE,   32'hFFFF_FFFF,  1'b1);
        send_request(REQ_DATASET, 32'd0,          1'b1);
        send_request(REQ_DATASET, 32'h0000_FF80,  1'b1);
        send_request(REQ_DATASET, 32'hFFFF_FF81,  1'b1);
        send_request(REQ_DATASET, 32'hFFFF_FFFF,  1'b1);
        send_request(REQ_UNUSED,  32'd0,          1'b1);
        send_request(REQ_UNUSED,  32'hFFFF_FFFF,  1'b1);

        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_random(rt, v);
            send_request(rt, v, !(n >= 30 && n < 60));
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("largest_prime_at_most_core: match");
        else
            $display("largest_prime_at_most_core: mismatch");
        $finish;
    end

endmodule
